FILE: rtl/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mexp_pkg;

  localparam int MEXP_WIDTH   = 64;
  localparam int APB_DATA_W   = 64;
  localparam int APB_ADDR_W   = 4;
  localparam int REG_SHIFT    = 3;
  localparam int MOD_RESET    = 10;
  localparam logic REG_MODULUS = 1'b0;

endpackage : mexp_pkg

`default_nettype wire

FILE: rtl/modular_exponentiation.sv
// Top level: square-and-multiply sequencer, modulus register and APB port.
// Uses mexp_pkg and mexp_mul_mod (which holds the shared mexp_add_mod).
//
//   channel   direction  handshake            payload
//   in        into       in_valid / in_stall  base, exponent
//   out       out of     out_valid/ out_stall power_result
//   config    into       APB write/read       modulus at byte address 0
//
// One modular product takes a load step, one step per double or add on the shared adder,
// and a handback. An item takes one product to reduce the base, WIDTH squarings and
// popcount(exponent) multiplies; an exponent of zero or a modulus of 0 or 1 offers its
// result in the cycle after accept.
// in_stall is high while an item is in work or its result waits. rst is synchronous.
`default_nettype none

module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [WIDTH-1:0]      base,
  input  wire logic [WIDTH-1:0]      exponent,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [WIDTH-1:0]      power_result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [2:0] {
    IDLE,
    REDUCE,
    SQUARE,
    MULT,
    OUT
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] ebits;
  logic [WIDTH-1:0] bred;
  logic [WIDTH-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic             mul_start;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;
  logic             accept;
  logic             last;

  assign pready       = 1'b1;
  assign prdata       = APB_DATA_W'(modulus);
  assign in_stall     = (state != IDLE);
  assign out_valid    = (state == OUT);
  assign power_result = r;
  assign accept       = in_valid && !in_stall;
  assign last         = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(MOD_RESET);
    end else if (psel && penable && pwrite && pready
                 && (paddr[REG_SHIFT] == REG_MODULUS)) begin
      modulus <= pwdata[WIDTH-1:0];
    end
  end

  mexp_mul_mod #(
    .WIDTH(WIDTH)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .x(mul_x),
    .y(mul_y),
    .m(modulus),
    .done(mul_done),
    .product(mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      mul_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            ebits <= exponent;
            if (exponent == '0) begin
              r     <= WIDTH'(1);
              state <= OUT;
            end else if (modulus <= WIDTH'(1)) begin
              r     <= '0;
              state <= OUT;
            end else begin
              mul_x     <= WIDTH'(1);
              mul_y     <= base;
              mul_start <= 1'b1;
              state     <= REDUCE;
            end
          end
        end
        REDUCE: begin
          if (mul_done) begin
            bred      <= mul_res;
            r         <= WIDTH'(1);
            cnt       <= CNT_W'(WIDTH - 1);
            mul_x     <= WIDTH'(1);
            mul_y     <= WIDTH'(1);
            mul_start <= 1'b1;
            state     <= SQUARE;
          end
        end
        SQUARE, MULT: begin
          if (mul_done) begin
            r <= mul_res;
            if ((state == SQUARE) && ebits[WIDTH-1]) begin
              mul_x     <= mul_res;
              mul_y     <= bred;
              mul_start <= 1'b1;
              state     <= MULT;
            end else if (last) begin
              state <= OUT;
            end else begin
              ebits     <= ebits << 1;
              cnt       <= cnt - CNT_W'(1);
              mul_x     <= mul_res;
              mul_y     <= mul_res;
              mul_start <= 1'b1;
              state     <= SQUARE;
            end
          end
        end
        OUT: begin
          if (!out_stall) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item accepted while a result waits");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == REDUCE || state == SQUARE || state == MULT))
    else $error("product finished outside an exponentiation");

  a_zero_exponent: assert property (@(posedge clk) disable iff (rst)
    (accept && exponent == '0) |=> (out_valid && power_result == WIDTH'(1)))
    else $error("zero exponent did not return one");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (state == REDUCE || state == SQUARE || state == MULT))
    else $error("product started outside an exponentiation");

endmodule : modular_exponentiation

`default_nettype wire

FILE: rtl/mexp_add_mod.sv
// Modular adder: (a + b) mod m for a and b below m.
// Uses mexp_pkg; shared arithmetic unit of mexp_mul_mod.
`default_nettype none

module mexp_add_mod
  import mexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] m,
  output logic      [WIDTH-1:0] s
);

  logic [WIDTH:0]   sum;
  logic [WIDTH+1:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, sum} - {2'b00, m};
  assign s    = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];

endmodule : mexp_add_mod

`default_nettype wire

FILE: rtl/mexp_mul_mod.sv
// Modular multiplier: (x * y) mod m by double-and-add over the bits of y.
// Uses mexp_pkg and one mexp_add_mod shared by the double and add steps.
`default_nettype none

module mexp_mul_mod
  import mexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic [WIDTH-1:0] m,
  output logic                  done,
  output logic      [WIDTH-1:0] product
);

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [1:0] {
    IDLE,
    DBL,
    ADD
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] xop;
  logic [WIDTH-1:0] ybits;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] acc_next;
  logic             last;

  assign addend  = (state == ADD) ? xop : acc;
  assign last    = (cnt == '0);
  assign product = acc;

  mexp_add_mod #(
    .WIDTH(WIDTH)
  ) u_add (
    .a(acc),
    .b(addend),
    .m(m),
    .s(acc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            acc   <= '0;
            xop   <= x;
            ybits <= y;
            cnt   <= CNT_W'(WIDTH - 1);
            state <= DBL;
          end
        end
        DBL: begin
          acc <= acc_next;
          if (ybits[WIDTH-1]) begin
            state <= ADD;
          end else begin
            ybits <= ybits << 1;
            cnt   <= cnt - CNT_W'(1);
            if (last) begin
              done  <= 1'b1;
              state <= IDLE;
            end
          end
        end
        ADD: begin
          acc   <= acc_next;
          ybits <= ybits << 1;
          cnt   <= cnt - CNT_W'(1);
          if (last) begin
            done  <= 1'b1;
            state <= IDLE;
          end else begin
            state <= DBL;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule : mexp_mul_mod

`default_nettype wire

FILE: sim/modular_exponentiation_test.sv
`timescale 1ns / 100ps
// Testbench for modular_exponentiation: directed and random items checked against
// a square-and-multiply predictor, with random idling on both channels.
// Depends on mexp_pkg and the block's RTL; reads no files.

module modular_exponentiation_test;
  import mexp_pkg::*;

  localparam int W = MEXP_WIDTH;
  localparam int UNUSED_REG = 1;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] TOP_BIT = {1'b1, {(W-1){1'b0}}};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [W-1:0] base;
  logic [W-1:0] exponent;
  logic out_valid;
  logic out_stall;
  logic [W-1:0] power_result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic [W-1:0] modulus_copy;
  logic [W-1:0] expected_powers[$];
  logic [W-1:0] oldest_power;
  int mismatches;
  bit calm;
  int hold_len = 0;
  int hold_id = 0;
  int hold_seen = 0;
  int stall_left = 0;

  modular_exponentiation #(.WIDTH(W)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .base(base),
    .exponent(exponent),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power_result(power_result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [W-1:0] mod_sum(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s[W] || s[W-1:0] >= m) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mod_product(input logic [W-1:0] x, input logic [W-1:0] y,
                                               input logic [W-1:0] m);
    logic [W-1:0] acc;
    acc = '0;
    for (int i = W - 1; i >= 0; i--) begin
      acc = mod_sum(acc, acc, m);
      if (y[i]) begin
        acc = mod_sum(acc, x, m);
      end
    end
    return acc;
  endfunction

  function automatic logic [W-1:0] expected_power(input logic [W-1:0] b, input logic [W-1:0] e,
                                                  input logic [W-1:0] m);
    logic [W-1:0] r;
    logic [W-1:0] br;
    if (e == '0) return W'(1);
    if (m <= W'(1)) return '0;
    br = b % m;
    r = W'(1);
    for (int i = W - 1; i >= 0; i--) begin
      r = mod_product(r, r, m);
      if (e[i]) begin
        r = mod_product(r, br, m);
      end
    end
    return r;
  endfunction

  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [W-1:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [W-1:0] random_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2, 3, 4: return wide_random();
      default: return wide_random() >> $urandom_range(1, W - 1);
    endcase
  endfunction

  function automatic logic [W-1:0] random_base(input logic [W-1:0] m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return m - W'(1);
      3: return m;
      default: return wide_random();
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [W-1:0] want,
                               input logic [W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        note_mismatch("unexpected power_result", '0, power_result);
      end else begin
        oldest_power = expected_powers.pop_front();
        if (power_result !== oldest_power) begin
          note_mismatch("power_result", oldest_power, power_result);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      stall_left = hold_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = idle_cycles() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic [W-1:0] b, input logic [W-1:0] e);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    base <= b;
    exponent <= e;
    do @(posedge clk); while (in_stall);
    expected_powers.push_back(expected_power(b, e, modulus_copy));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input int index, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(index) << REG_SHIFT;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == int'(REG_MODULUS)) begin
      modulus_copy = value[W-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_modulus_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(REG_MODULUS) << REG_SHIFT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[W-1:0] !== modulus_copy) begin
      note_mismatch("modulus readback", modulus_copy, prdata[W-1:0]);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_modulus(input logic [W-1:0] m);
    drain_results();
    write_register(int'(REG_MODULUS), APB_DATA_W'(m));
    check_modulus_readback();
  endtask

  task automatic test_reset_modulus();
    check_modulus_readback();
    send_item(W'(7), W'(3));
    send_item('0, '0);
    send_item('0, W'(5));
    send_item(ALL_ONES, ALL_ONES);
    drain_results();
  endtask

  task automatic test_modulus_one();
    set_modulus(W'(1));
    send_item(W'(9), '0);
    send_item(ALL_ONES, W'(1));
    send_item(W'(2), ALL_ONES);
    drain_results();
  endtask

  task automatic test_wide_modulus();
    set_modulus(ALL_ONES);
    send_item(ALL_ONES, W'(1));
    send_item(ALL_ONES - W'(1), ALL_ONES);
    send_item(TOP_BIT, W'(2));
    send_item(W'(2), W'(W - 1));
    set_modulus(TOP_BIT | W'(1));
    send_item(TOP_BIT, ALL_ONES);
    send_item(ALL_ONES, W'(3));
    set_modulus(W'(2));
    send_item(ALL_ONES, ALL_ONES);
    send_item(TOP_BIT, W'(1));
    drain_results();
  endtask

  task automatic test_unused_register();
    write_register(UNUSED_REG, APB_DATA_W'(7));
    check_modulus_readback();
    send_item(W'(3), W'(5));
    drain_results();
  endtask

  task automatic test_receiver_hold();
    hold_len = 3000;
    hold_id++;
    send_item(W'(5), '0);
    send_item(ALL_ONES, '0);
    send_item(W'(3), W'(2));
    send_item('0, '0);
    send_item(ALL_ONES, W'(1));
    drain_results();
  endtask

  task automatic test_random_items();
    logic [W-1:0] m;
    int count;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: m = W'($urandom_range(2, 1000));
        1: m = W'($urandom);
        2: m = wide_random() | TOP_BIT;
        3: m = ALL_ONES;
        4: m = W'(1);
        5: m = TOP_BIT;
        6: m = wide_random();
        default: m = W'(2);
      endcase
      if (m == '0) m = W'(1);
      set_modulus(m);
      calm = (phase == 2 || phase == 5);
      count = (phase == 4) ? 8 : 10;
      for (int k = 0; k < count; k++) begin
        send_item(random_base(m), random_exponent());
      end
    end
    calm = 1'b0;
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    base = '0;
    exponent = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    mismatches = 0;
    modulus_copy = W'(MOD_RESET);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_modulus();
    test_modulus_one();
    test_wide_modulus();
    test_unused_register();
    test_receiver_hold();
    test_random_items();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("** modular_exponentiation: FAILED **");
    $finish;
  end

endmodule
